// File: rtl/pbrf_pkg.sv
// Shared types and constants for the polynomial bisection root finder.
// Used by pbrf_horner_unit and polynomial_bisection_root_finder_unit.
`timescale 1ns / 1ps
`default_nettype none

package pbrf_pkg;

    localparam int MAX_DEGREE_DEF = 15;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGREE    = 3'd0,
        REG_STOP_MODE = 3'd1,
        REG_REL_TOL   = 3'd2,
        REG_ULP_LIMIT = 3'd3,
        REG_MAX_ITER  = 3'd4
    } cfg_reg_t;

    localparam logic [3:0]  DEGREE_RST    = 4'd2;
    localparam logic        STOP_MODE_RST = 1'b0;
    localparam logic [31:0] REL_TOL_RST   = 32'd429;
    localparam logic [7:0]  ULP_LIMIT_RST = 8'd3;
    localparam logic [15:0] MAX_ITER_RST  = 16'd64;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SOLVE = 1'b1;

    localparam logic STOP_REL = 1'b0;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_EXACT     = 2'd1;
    localparam logic [1:0] ST_CAP       = 2'd2;

    // operand selection for the shared 32x32 multiplier
    typedef enum logic [2:0] {
        MUL_L_LO,
        MUL_L_HI,
        MUL_M_LO,
        MUL_M_HI,
        MUL_REL
    } mul_sel_t;

    typedef struct packed {
        logic     clear;
        mul_sel_t mul_sel;
        logic     comb_m;
        logic     add_l;
        logic     add_m;
    } pbrf_ctrl_t;

    typedef struct packed {
        logic zero_l;
        logic neg_l;
        logic zero_m;
        logic neg_m;
    } pbrf_sign_t;

endpackage

`default_nettype wire

// File: rtl/pbrf_horner_unit.sv
// Horner datapath: shared 32x32 multiplier, product combine and clamp,
// saturating coefficient add; two sums kept in sign-magnitude. Uses pbrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbrf_horner_unit #(
    parameter int FRAC_BITS = pbrf_pkg::FRAC_BITS_DEF
) (
    input  wire                      clk,
    input  pbrf_pkg::pbrf_ctrl_t     ctrl,
    input  wire [31:0]               xm_l,
    input  wire                      xneg_l,
    input  wire [31:0]               xm_m,
    input  wire                      xneg_m,
    input  wire signed [31:0]        coef,
    input  wire [31:0]               rel_tol,
    input  wire [31:0]               mid_mag,
    output pbrf_pkg::pbrf_sign_t     sign,
    output logic [63:0]              prod
);
    import pbrf_pkg::*;

    localparam int PW = 96;
    localparam int RW = PW - FRAC_BITS;
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

    logic [63:0] mag_l_reg;
    logic        neg_l_reg;
    logic [63:0] mag_m_reg;
    logic        neg_m_reg;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic [63:0] r_reg;
    logic        pneg_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    logic [PW-1:0] wide;
    logic [RW-1:0] rfull;
    logic          pneg;
    logic [63:0]   limit;
    logic [63:0]   r_next;

    logic [65:0] coef66;
    logic [65:0] r66;
    logic [65:0] t;
    logic [65:0] u;
    logic        over_pos;
    logic        over_neg;
    logic [63:0] mag_next;
    logic        neg_next;

    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_L_LO:
            begin
                mul_a = mag_l_reg[31:0];
                mul_b = xm_l;
            end
            MUL_L_HI:
            begin
                mul_a = mag_l_reg[63:32];
                mul_b = xm_l;
            end
            MUL_M_LO:
            begin
                mul_a = mag_m_reg[31:0];
                mul_b = xm_m;
            end
            MUL_M_HI:
            begin
                mul_a = mag_m_reg[63:32];
                mul_b = xm_m;
            end
            MUL_REL:
            begin
                mul_a = rel_tol;
                mul_b = mid_mag;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // full |sum|*|x| from the two halves, then >> FRAC_BITS and clamp
    assign wide  = {hi_reg + {32'd0, lo_reg[63:32]}, lo_reg[31:0]};
    assign rfull = wide[PW-1:FRAC_BITS];
    assign pneg  = ctrl.comb_m ? (neg_m_reg ^ xneg_m) : (neg_l_reg ^ xneg_l);
    assign limit = pneg ? NEG_MAX : POS_MAX;
    assign r_next = (rfull > RW'(limit)) ? limit : rfull[63:0];

    // t = coef +/- r, u = -t formed alongside so the magnitude needs no second pass
    assign coef66 = {{34{coef[31]}}, coef};
    assign r66    = {2'b00, r_reg};
    assign t = coef66 + (pneg_reg ? ~r66 : r66) + 66'(pneg_reg);
    assign u = ~coef66 + (pneg_reg ? r66 : ~r66) + (pneg_reg ? 66'd1 : 66'd2);

    assign over_pos = !t[65] && (t[64:63] != 2'b00);
    assign over_neg = t[65] && (t[64:63] != 2'b11);
    assign neg_next = t[65];

    always_comb
    begin
        if (over_pos)
        begin
            mag_next = POS_MAX;
        end
        else if (over_neg)
        begin
            mag_next = NEG_MAX;
        end
        else if (t[65])
        begin
            mag_next = u[63:0];
        end
        else
        begin
            mag_next = t[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_sel == MUL_L_HI || ctrl.mul_sel == MUL_M_HI)
        begin
            hi_reg <= mul_p;
        end
        else
        begin
            lo_reg <= mul_p;
        end
        r_reg    <= r_next;
        pneg_reg <= pneg;
        if (ctrl.clear)
        begin
            mag_l_reg <= 64'd0;
            neg_l_reg <= 1'b0;
            mag_m_reg <= 64'd0;
            neg_m_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.add_l)
            begin
                mag_l_reg <= mag_next;
                neg_l_reg <= neg_next;
            end
            if (ctrl.add_m)
            begin
                mag_m_reg <= mag_next;
                neg_m_reg <= neg_next;
            end
        end
    end

    assign sign.zero_l = (mag_l_reg == 64'd0);
    assign sign.neg_l  = neg_l_reg;
    assign sign.zero_m = (mag_m_reg == 64'd0);
    assign sign.neg_m  = neg_m_reg;
    assign prod        = lo_reg;

endmodule

`default_nettype wire

// File: rtl/polynomial_bisection_root_finder_unit.sv
// Solve: each bisection step evaluates the degree-d polynomial at two points by Horner,
// sharing the one 32x32 multiplier for both product halves at both points.
// Load: taken while idle, no word out. One solve at a time; busy high meanwhile.
// Results appear for one cycle with done; the receiver cannot stall.
// Reset sets registers to defaults and idles; the coefficient store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module polynomial_bisection_root_finder_unit #(
    parameter int MAX_DEGREE = pbrf_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = pbrf_pkg::FRAC_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire                            func,
    input  wire [3:0]                      coef_index,
    input  wire signed [31:0]              coef_value,
    input  wire signed [31:0]              left_end,
    input  wire signed [31:0]              right_end,
    input  wire                            cfg_write,
    input  wire [pbrf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [pbrf_pkg::CFG_W-1:0]      cfg_data,
    output logic                           done,
    output logic signed [31:0]             root,
    output logic [31:0]                    last_step,
    output logic [1:0]                     status,
    output logic [15:0]                    iterations
);
    import pbrf_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_PREP,
        S_EVAL,
        S_DECIDE,
        S_DIFF,
        S_REL,
        S_CHECK
    } state_t;

    logic [3:0]  degree_reg;
    logic        stop_mode_reg;
    logic [31:0] rel_tol_reg;
    logic [7:0]  ulp_limit_reg;
    logic [15:0] max_iter_reg;

    logic signed [31:0] coef_mem [DEPTH];
    logic signed [31:0] coef_reg;

    state_t             state_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] mid_reg;
    logic signed [31:0] old_mid_reg;
    logic [31:0]        step_reg;
    logic [31:0]        mid_mag_reg;
    logic [31:0]        xm_l_reg;
    logic               xneg_l_reg;
    logic [31:0]        xm_m_reg;
    logic               xneg_m_reg;
    logic [15:0]        iter_reg;
    logic [1:0]         phase_reg;
    logic [IW-1:0]      term_reg;
    logic               first_reg;
    logic               tail_reg;
    logic               init_reg;
    logic               done_reg;
    logic signed [31:0] root_reg;
    logic [31:0]        last_step_reg;
    logic [1:0]         status_reg;
    logic [15:0]        iterations_reg;

    pbrf_ctrl_t  ctrl;
    pbrf_sign_t  sign;
    logic [63:0] prod;

    logic          load_acc;
    logic [IW-1:0] deg_eff;
    logic [15:0]   cap;
    logic [32:0]   mid_sum;
    logic [32:0]   d1;
    logic [32:0]   d2;
    logic          stop_hit;

    assign busy     = (state_reg != S_IDLE);
    assign load_acc = start && !busy && (func == FUNC_LOAD)
                      && ({28'd0, coef_index} <= 32'(MAX_DEGREE));
    assign deg_eff  = ({28'd0, degree_reg} > 32'(MAX_DEGREE)) ? IW'(MAX_DEGREE)
                                                               : IW'(degree_reg);
    assign cap      = (max_iter_reg == 16'd0) ? 16'd1 : max_iter_reg;
    assign mid_sum  = {a_reg[31], a_reg} + {b_reg[31], b_reg};
    assign d1       = {mid_reg[31], mid_reg} - {old_mid_reg[31], old_mid_reg};
    assign d2       = {old_mid_reg[31], old_mid_reg} - {mid_reg[31], mid_reg};
    assign stop_hit = (stop_mode_reg == STOP_REL) ? ({step_reg, 32'd0} <= prod)
                                                  : (step_reg <= {24'd0, ulp_limit_reg});

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg    <= DEGREE_RST;
            stop_mode_reg <= STOP_MODE_RST;
            rel_tol_reg   <= REL_TOL_RST;
            ulp_limit_reg <= ULP_LIMIT_RST;
            max_iter_reg  <= MAX_ITER_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEGREE:    degree_reg    <= cfg_data[3:0];
                REG_STOP_MODE: stop_mode_reg <= cfg_data[0];
                REG_REL_TOL:   rel_tol_reg   <= cfg_data[31:0];
                REG_ULP_LIMIT: ulp_limit_reg <= cfg_data[7:0];
                REG_MAX_ITER:  max_iter_reg  <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // coefficient store, registered read once per Horner term
    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            coef_mem[IW'(coef_index)] <= coef_value;
        end
        if (state_reg == S_EVAL && phase_reg == 2'd1)
        begin
            coef_reg <= coef_mem[term_reg];
        end
    end

    // Four-phase schedule per term: multiplier takes left lo/hi then mid lo/hi;
    // left add on phase 3, mid add on phase 1 of the next term.
    always_comb
    begin
        ctrl         = '0;
        ctrl.mul_sel = MUL_L_LO;
        case (state_reg)
            S_PREP:
            begin
                ctrl.clear = 1'b1;
            end
            S_EVAL:
            begin
                case (phase_reg)
                    2'd0:    ctrl.mul_sel = MUL_L_LO;
                    2'd1:    ctrl.mul_sel = MUL_L_HI;
                    2'd2:    ctrl.mul_sel = MUL_M_LO;
                    default: ctrl.mul_sel = MUL_M_HI;
                endcase
                ctrl.comb_m = (phase_reg == 2'd0);
                ctrl.add_l  = (phase_reg == 2'd3) && !tail_reg;
                ctrl.add_m  = (phase_reg == 2'd1) && !first_reg;
            end
            S_REL:
            begin
                ctrl.mul_sel = MUL_REL;
            end
            default:
            begin
                ctrl.clear = 1'b0;
            end
        endcase
    end

    pbrf_horner_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_horner (
        .clk     (clk),
        .ctrl    (ctrl),
        .xm_l    (xm_l_reg),
        .xneg_l  (xneg_l_reg),
        .xm_m    (xm_m_reg),
        .xneg_m  (xneg_m_reg),
        .coef    (coef_reg),
        .rel_tol (rel_tol_reg),
        .mid_mag (mid_mag_reg),
        .sign    (sign),
        .prod    (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            a_reg          <= 32'sd0;
            b_reg          <= 32'sd0;
            mid_reg        <= 32'sd0;
            old_mid_reg    <= 32'sd0;
            step_reg       <= 32'd0;
            mid_mag_reg    <= 32'd0;
            xm_l_reg       <= 32'd0;
            xneg_l_reg     <= 1'b0;
            xm_m_reg       <= 32'd0;
            xneg_m_reg     <= 1'b0;
            iter_reg       <= 16'd0;
            phase_reg      <= 2'd0;
            term_reg       <= '0;
            first_reg      <= 1'b0;
            tail_reg       <= 1'b0;
            init_reg       <= 1'b0;
            done_reg       <= 1'b0;
            root_reg       <= 32'sd0;
            last_step_reg  <= 32'd0;
            status_reg     <= ST_CONVERGED;
            iterations_reg <= 16'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && func == FUNC_SOLVE)
                    begin
                        a_reg     <= left_end;
                        b_reg     <= right_end;
                        step_reg  <= 32'd0;
                        iter_reg  <= 16'd0;
                        init_reg  <= 1'b1;
                        state_reg <= S_MID;
                    end
                end
                S_MID:
                begin
                    // floor((a + b) / 2)
                    mid_reg   <= mid_sum[32:1];
                    init_reg  <= 1'b0;
                    state_reg <= init_reg ? S_PREP : S_DIFF;
                end
                S_PREP:
                begin
                    xm_l_reg   <= a_reg[31] ? (~a_reg + 32'd1) : a_reg;
                    xneg_l_reg <= a_reg[31];
                    xm_m_reg   <= mid_reg[31] ? (~mid_reg + 32'd1) : mid_reg;
                    xneg_m_reg <= mid_reg[31];
                    iter_reg   <= iter_reg + 16'd1;
                    phase_reg  <= 2'd0;
                    term_reg   <= deg_eff;
                    first_reg  <= 1'b1;
                    tail_reg   <= 1'b0;
                    state_reg  <= S_EVAL;
                end
                S_EVAL:
                begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd3)
                    begin
                        first_reg <= 1'b0;
                        if (term_reg == '0)
                        begin
                            tail_reg <= 1'b1;
                        end
                        else
                        begin
                            term_reg <= term_reg - IW'(1);
                        end
                    end
                    // tail: the mid point's last add lands this edge
                    if (tail_reg && phase_reg == 2'd1)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (sign.zero_l || sign.zero_m)
                    begin
                        root_reg       <= sign.zero_l ? a_reg : mid_reg;
                        last_step_reg  <= step_reg;
                        status_reg     <= ST_EXACT;
                        iterations_reg <= iter_reg;
                        done_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        if (sign.neg_l != sign.neg_m)
                        begin
                            b_reg <= mid_reg;
                        end
                        else
                        begin
                            a_reg <= mid_reg;
                        end
                        old_mid_reg <= mid_reg;
                        state_reg   <= S_MID;
                    end
                end
                S_DIFF:
                begin
                    step_reg    <= d1[32] ? d2[31:0] : d1[31:0];
                    mid_mag_reg <= mid_reg[31] ? (~mid_reg + 32'd1) : mid_reg;
                    state_reg   <= S_REL;
                end
                S_REL:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (stop_hit || iter_reg >= cap)
                    begin
                        root_reg       <= mid_reg;
                        last_step_reg  <= step_reg;
                        status_reg     <= stop_hit ? ST_CONVERGED : ST_CAP;
                        iterations_reg <= iter_reg;
                        done_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_PREP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign root       = root_reg;
    assign last_step  = last_step_reg;
    assign status     = status_reg;
    assign iterations = iterations_reg;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result word");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a solve in progress");

    a_iter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (iterations != 16'd0))
        else $error("result word reports no bisection step");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_LOAD) |=> !busy)
        else $error("coefficient load made the unit busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_CONVERGED || status == ST_EXACT || status == ST_CAP))
        else $error("undefined status code on result word");
`endif

endmodule

`default_nettype wire
